// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property a implies property b at every clock edge, held off in reset.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// Property a implies property b in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ===== rtl/i8dq_pkg.sv =====
// Package with types and constants of the int8 dot product epilogue.
`timescale 1ns / 1ps
package i8dq_pkg;
	localparam logic [2:0] REG_OUTPUT_INT8 = 3'd0;
	localparam logic [2:0] REG_USE_INPUT_SCALE = 3'd1;
	localparam logic [2:0] REG_USE_INPUT_BIAS = 3'd2;
	localparam logic [2:0] REG_USE_BIAS = 3'd3;
	localparam logic [2:0] REG_CLAMP_ENABLE = 3'd4;
	localparam logic [2:0] REG_CLAMP_LOW = 3'd5;
	localparam logic [2:0] REG_CLAMP_HIGH = 3'd6;

	// Epilogue step that the datapath performs this cycle.
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_SCALE = 3'd1,
		OP_INSCALE = 3'd2,
		OP_SRCBIAS = 3'd3,
		OP_INBIAS = 3'd4,
		OP_FINISH = 3'd5
	} op_t;

	typedef struct packed {
		logic load;
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic use_input_scale;
		logic use_input_bias;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) r = 32'sh7fffffff;
		else if (v < -66'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

// ===== rtl/i8dq_ctrl.sv =====
// Controller that sequences the block-end epilogue steps.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i8dq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input i8dq_pkg::dp_stat_t stat,
	input logic out_ready,
	output i8dq_pkg::dp_cmd_t cmd,
	output logic busy
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCALE = 6'b000010,
		ST_INSCALE = 6'b000100,
		ST_SRCBIAS = 6'b001000,
		ST_INBIAS = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;
	state_t state_q;

	// Next state: skip optional steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_SCALE;
				ST_SCALE: state_q <= stat.use_input_scale ? ST_INSCALE : ST_SRCBIAS;
				ST_INSCALE: state_q <= ST_SRCBIAS;
				ST_SRCBIAS: state_q <= stat.use_input_bias ? ST_INBIAS : ST_FINISH;
				ST_INBIAS: state_q <= ST_FINISH;
				ST_FINISH: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		unique case (state_q)
			ST_SCALE: cmd.op = i8dq_pkg::OP_SCALE;
			ST_INSCALE: cmd.op = i8dq_pkg::OP_INSCALE;
			ST_SRCBIAS: cmd.op = i8dq_pkg::OP_SRCBIAS;
			ST_INBIAS: cmd.op = i8dq_pkg::OP_INBIAS;
			ST_FINISH: cmd.op = out_ready ? i8dq_pkg::OP_FINISH : i8dq_pkg::OP_NONE;
			default: cmd.op = i8dq_pkg::OP_NONE;
		endcase
	end
	assign busy = (state_q != ST_IDLE);

	`ASSERT_NEXT(a_start_goes_busy, clk, arst_n, cmd.load, busy)
	`ASSERT_IMPL(a_load_only_idle, clk, arst_n, cmd.load, state_q == ST_IDLE)
	`ASSERT_NEXT(a_finish_waits, clk, arst_n, state_q == ST_FINISH && !out_ready,
		state_q == ST_FINISH)
endmodule

// ===== rtl/i8dq_datapath.sv =====
// Datapath: multiply-accumulate, epilogue arithmetic and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i8dq_datapath #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic mac_en,
	input logic signed [7:0] activation,
	input logic signed [7:0] weight_byte,
	input logic final_block,
	input logic signed [31:0] weight_scale,
	input logic signed [31:0] input_scale,
	input logic signed [31:0] source_sum,
	input logic signed [31:0] weight_bias,
	input logic signed [31:0] input_bias,
	input logic signed [31:0] kernel_sum,
	input logic signed [31:0] output_bias,
	input logic output_int8,
	input logic use_bias,
	input logic clamp_enable,
	input logic signed [31:0] clamp_low,
	input logic signed [31:0] clamp_high,
	input i8dq_pkg::dp_cmd_t cmd,
	input logic out_ready,
	output logic out_valid,
	output logic signed [31:0] result_value
);
	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

	logic [31:0] acc_q;
	logic signed [31:0] partial_q, v_q, res_q;
	logic signed [31:0] ws_q, is_q, ss_q, wb_q, ib_q, ks_q, ob_q;
	logic fin_q, valid_q;
	logic signed [31:0] mul_a, mul_b, prod_sat, sum_v, part_v, fin_v, clamped;
	logic signed [63:0] prod;
	logic [63:0] mag;
	logic [63:0] fin_mag;
	logic signed [63:0] rnd;
	logic signed [31:0] rnd_res;
	logic [31:0] acc_next;

	// Shared 32x32 multiplier with saturation, and rounding in all but the scale step.
	always_comb begin
		unique case (cmd.op)
			i8dq_pkg::OP_SCALE: begin mul_a = acc_q; mul_b = ws_q; end
			i8dq_pkg::OP_INSCALE: begin mul_a = v_q; mul_b = is_q; end
			i8dq_pkg::OP_SRCBIAS: begin mul_a = ss_q; mul_b = wb_q; end
			default: begin mul_a = ib_q; mul_b = ks_q; end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
		mag = prod[63] ? 64'(-prod) : 64'(prod);
		mag = (mag + HALF) >> FRAC_BITS;
		rnd = prod[63] ? -$signed(mag) : $signed(mag);
		if (cmd.op == i8dq_pkg::OP_SCALE) prod_sat = i8dq_pkg::sat32(66'(prod));
		else prod_sat = i8dq_pkg::sat32(66'(rnd));
		sum_v = i8dq_pkg::sat32(66'(v_q) + 66'(prod_sat));
	end

	// Final combination, clamp, rounding to an integer and the next accumulator value.
	always_comb begin
		// Running block sum in real mode, kept without the output bias.
		part_v = i8dq_pkg::sat32(66'(v_q) + 66'(partial_q));
		if (output_int8) fin_v = i8dq_pkg::sat32(66'(v_q) + 66'(ob_q));
		else if (use_bias) fin_v = i8dq_pkg::sat32(66'(part_v) + 66'(ob_q));
		else fin_v = part_v;
		clamped = fin_v;
		if (output_int8 || clamp_enable) begin
			if (clamped < clamp_low) clamped = clamp_low;
			if (clamped > clamp_high) clamped = clamp_high;
		end
		fin_mag = clamped[31] ? 64'(-64'(clamped)) : 64'(clamped);
		rnd_res = 32'(signed'((fin_mag + HALF) >> FRAC_BITS));
		rnd_res = clamped[31] ? -rnd_res : rnd_res;
		acc_next = acc_q + 32'(16'(activation) * 16'(weight_byte));
	end

	// Accumulator, block partial and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			partial_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.op == i8dq_pkg::OP_SCALE) acc_q <= '0;
			else if (cmd.load) acc_q <= acc_next;
			else if (mac_en) acc_q <= acc_next;
			if (cmd.op == i8dq_pkg::OP_FINISH) begin
				if (output_int8 || fin_q) partial_q <= '0;
				else partial_q <= part_v;
			end
			if (cmd.op == i8dq_pkg::OP_FINISH && fin_q) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ws_q <= weight_scale; is_q <= input_scale; ss_q <= source_sum;
			wb_q <= weight_bias; ib_q <= input_bias; ks_q <= kernel_sum;
			ob_q <= output_bias; fin_q <= final_block;
		end
		if (cmd.op == i8dq_pkg::OP_SCALE) v_q <= prod_sat;
		else if (cmd.op == i8dq_pkg::OP_INSCALE) v_q <= prod_sat;
		else if (cmd.op == i8dq_pkg::OP_SRCBIAS || cmd.op == i8dq_pkg::OP_INBIAS)
			v_q <= sum_v;
		if (cmd.op == i8dq_pkg::OP_FINISH && fin_q)
			res_q <= output_int8 ? 32'(signed'(rnd_res[7:0])) : clamped;
	end

	assign out_valid = valid_q;
	assign result_value = res_q;

	`ASSERT_NEXT(a_scale_clears_acc, clk, arst_n, cmd.op == i8dq_pkg::OP_SCALE,
		acc_q == '0)
	`ASSERT_NEXT(a_int8_partial_zero, clk, arst_n,
		cmd.op == i8dq_pkg::OP_FINISH && output_int8, partial_q == '0)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, valid_q && !out_ready,
		valid_q && $stable(res_q))
endmodule

// ===== rtl/int8_dot_dequant_epilogue.sv =====
// Top level of the int8 dot product with dequantizing epilogue.
// A pair without block end goes into the accumulator register, one word per cycle
// while in_ready is high. A block-end word runs scale, optional input scale,
// source bias, optional input bias, final step, through one shared 32x32 multiplier.
// The result word of a final block appears in the cycle after the final step; input
// waits until taken. Reset clears accumulator, partial and valid; config gets defaults.
`timescale 1ns / 1ps
module int8_dot_dequant_epilogue #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [7:0] activation,
	input logic signed [7:0] weight_byte,
	input logic end_of_block,
	input logic final_block,
	input logic signed [31:0] weight_scale,
	input logic signed [31:0] input_scale,
	input logic signed [31:0] source_sum,
	input logic signed [31:0] weight_bias,
	input logic signed [31:0] input_bias,
	input logic signed [31:0] kernel_sum,
	input logic signed [31:0] output_bias,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] result_value
);
	logic output_int8_q, use_input_scale_q, use_input_bias_q, use_bias_q, clamp_enable_q;
	logic signed [31:0] clamp_low_q, clamp_high_q;
	logic busy, fire, res_valid, fin_ready;
	i8dq_pkg::dp_cmd_t cmd;
	i8dq_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;
	assign in_ready = !busy && !res_valid;
	assign fire = in_valid && in_ready;
	assign stat.use_input_scale = use_input_scale_q;
	assign stat.use_input_bias = use_input_bias_q;
	assign fin_ready = 1'b1;
	assign out_valid = res_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_int8_q <= 1'b0; use_input_scale_q <= 1'b0; use_input_bias_q <= 1'b0;
			use_bias_q <= 1'b1; clamp_enable_q <= 1'b0;
			clamp_low_q <= -32'sd8388608; clamp_high_q <= 32'sd8323072;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				i8dq_pkg::REG_OUTPUT_INT8: output_int8_q <= cfg_data[0];
				i8dq_pkg::REG_USE_INPUT_SCALE: use_input_scale_q <= cfg_data[0];
				i8dq_pkg::REG_USE_INPUT_BIAS: use_input_bias_q <= cfg_data[0];
				i8dq_pkg::REG_USE_BIAS: use_bias_q <= cfg_data[0];
				i8dq_pkg::REG_CLAMP_ENABLE: clamp_enable_q <= cfg_data[0];
				i8dq_pkg::REG_CLAMP_LOW: clamp_low_q <= cfg_data;
				i8dq_pkg::REG_CLAMP_HIGH: clamp_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	i8dq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(fire && end_of_block), .stat(stat),
		.out_ready(fin_ready), .cmd(cmd), .busy(busy)
	);

	i8dq_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .mac_en(fire),
		.activation(activation), .weight_byte(weight_byte), .final_block(final_block),
		.weight_scale(weight_scale), .input_scale(input_scale), .source_sum(source_sum),
		.weight_bias(weight_bias), .input_bias(input_bias), .kernel_sum(kernel_sum),
		.output_bias(output_bias), .output_int8(output_int8_q), .use_bias(use_bias_q),
		.clamp_enable(clamp_enable_q), .clamp_low(clamp_low_q), .clamp_high(clamp_high_q),
		.cmd(cmd), .out_ready(out_ready), .out_valid(res_valid), .result_value(result_value)
	);
endmodule
